@@ design/bdq_pkg.sv @@
// shared constants, command codes and control types for the byte deque
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

  typedef struct packed {
    logic push_back;
    logic push_front;
    logic pop_back;
    logic pop_front;
    logic clear;
    logic load_status;
    logic status_ok;
    logic dump_begin;
    logic dump_beat;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic dump_last;
    logic out_busy;
  } dp_status_t;

endpackage

@@ design/bdq_ctrl.sv @@
// command decoder and sequencer for the byte deque
module bdq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bdq_pkg::CMD_W-1:0]   command,
  input  logic                        out_stall,
  input  bdq_pkg::dp_status_t         status,
  output bdq_pkg::dp_cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !status.out_busy || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        in_stall = !slot_free;
        if (in_valid && slot_free) begin
          unique case (command)
            bdq_pkg::CMD_PUSH_BACK: begin
              cmd.push_back   = !status.full;
              cmd.load_status = 1'b1;
              cmd.status_ok   = !status.full;
            end
            bdq_pkg::CMD_PUSH_FRONT: begin
              cmd.push_front  = !status.full;
              cmd.load_status = 1'b1;
              cmd.status_ok   = !status.full;
            end
            bdq_pkg::CMD_POP_BACK: begin
              cmd.pop_back    = !status.empty;
              cmd.load_status = 1'b1;
              cmd.status_ok   = !status.empty;
            end
            bdq_pkg::CMD_POP_FRONT: begin
              cmd.pop_front   = !status.empty;
              cmd.load_status = 1'b1;
              cmd.status_ok   = !status.empty;
            end
            bdq_pkg::CMD_CLEAR: begin
              cmd.clear       = 1'b1;
              cmd.load_status = 1'b1;
              cmd.status_ok   = 1'b1;
            end
            bdq_pkg::CMD_DUMP: begin
              if (status.empty) begin
                cmd.load_status = 1'b1;
                cmd.status_ok   = 1'b1;
              end else begin
                cmd.dump_begin = 1'b1;
                state_next     = ST_DUMP;
              end
            end
            default: begin
              cmd.load_status = 1'b1;
              cmd.status_ok   = 1'b0;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          cmd.dump_beat = 1'b1;
          if (status.dump_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/bdq_datapath.sv @@
// ring buffer store, pointers and output register for the byte deque
module bdq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bdq_pkg::BYTE_W-1:0]   value,
  input  logic                         out_stall,
  input  bdq_pkg::dp_cmd_t             cmd,
  output bdq_pkg::dp_status_t          status,
  output logic                         out_valid,
  output logic                         ok,
  output logic [bdq_pkg::BYTE_W-1:0]   data,
  output logic                         data_valid,
  output logic                         last,
  output logic [bdq_pkg::CNT_W-1:0]    count,
  output logic                         empty_res
);

  localparam int SUM_W = bdq_pkg::PTR_W + 1;

  logic [bdq_pkg::BYTE_W-1:0] store [bdq_pkg::DEPTH];

  logic [bdq_pkg::PTR_W-1:0] head;
  logic [bdq_pkg::PTR_W-1:0] head_next;
  logic [bdq_pkg::CNT_W-1:0] fill;
  logic [bdq_pkg::CNT_W-1:0] fill_next;
  logic [bdq_pkg::PTR_W-1:0] idx;

  logic [bdq_pkg::PTR_W-1:0] head_inc;
  logic [bdq_pkg::PTR_W-1:0] head_dec;
  logic [bdq_pkg::PTR_W-1:0] tail_pos;
  logic [bdq_pkg::PTR_W-1:0] read_pos;
  logic [bdq_pkg::PTR_W-1:0] write_pos;
  logic                      write_en;

  function automatic logic [bdq_pkg::PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] sum);
    if (sum >= SUM_W'(bdq_pkg::DEPTH)) begin
      return bdq_pkg::PTR_W'(sum - SUM_W'(bdq_pkg::DEPTH));
    end
    return sum[bdq_pkg::PTR_W-1:0];
  endfunction

  assign head_inc = (head == bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1)) ? '0
                                                                   : head + 1'b1;
  assign head_dec = (head == '0) ? bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1) : head - 1'b1;
  assign tail_pos = ring_wrap(SUM_W'(head) + SUM_W'(fill));
  assign read_pos = ring_wrap(SUM_W'(head) + SUM_W'(idx));

  assign write_en  = cmd.push_back || cmd.push_front;
  assign write_pos = cmd.push_front ? head_dec : tail_pos;

  assign status.full      = (fill == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign status.empty     = (fill == '0);
  assign status.dump_last = (bdq_pkg::CNT_W'(idx) + bdq_pkg::CNT_W'(1) == fill);
  assign status.out_busy  = out_valid;

  assign count     = fill;
  assign empty_res = (fill == '0);

  always_comb begin
    head_next = head;
    fill_next = fill;
    if (cmd.clear) begin
      head_next = '0;
      fill_next = '0;
    end else if (cmd.push_back) begin
      fill_next = fill + 1'b1;
    end else if (cmd.push_front) begin
      head_next = head_dec;
      fill_next = fill + 1'b1;
    end else if (cmd.pop_back) begin
      fill_next = fill - 1'b1;
    end else if (cmd.pop_front) begin
      head_next = head_inc;
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      head <= head_next;
      fill <= fill_next;
      if (cmd.load_status || cmd.dump_beat) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_begin) begin
      idx <= '0;
    end else if (cmd.dump_beat) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      store[write_pos] <= value;
    end
  end

  // one beat per cycle while the output is not stalled, straight from the store into the output register
  always_ff @(posedge clk) begin
    if (cmd.dump_beat) begin
      ok         <= 1'b1;
      data       <= store[read_pos];
      data_valid <= 1'b1;
      last       <= status.dump_last;
    end else if (cmd.load_status) begin
      ok         <= cmd.status_ok;
      data       <= '0;
      data_valid <= 1'b0;
      last       <= 1'b1;
    end
  end

endmodule

@@ design/byte_deque.sv @@
// top level of the byte deque
// Bounded double-ended queue of bytes held in a ring buffer of bdq_pkg::DEPTH entries.
// Push back/front, pop back/front and clear each give one result beat; an input beat
// is taken in the same cycle the previous result is taken, so these commands run at
// one per cycle. A dump of n stored bytes first sets up its read index and then gives
// n beats, one per cycle while the output is not stalled, from the store's single
// read port (a dump of an empty queue gives one beat with data_valid low). No input
// beat is taken until the last dump beat has been loaded into the output register.
// count and empty_res show the state after the command; during a dump they show the
// unchanged state.
module byte_deque (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bdq_pkg::CMD_W-1:0]    command,
  input  logic [bdq_pkg::BYTE_W-1:0]   value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [bdq_pkg::BYTE_W-1:0]   data,
  output logic                         data_valid,
  output logic                         last,
  output logic [bdq_pkg::CNT_W-1:0]    count,
  output logic                         empty_res
);

  bdq_pkg::dp_cmd_t    cmd;
  bdq_pkg::dp_status_t status;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bdq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .ok         (ok),
    .data       (data),
    .data_valid (data_valid),
    .last       (last),
    .count      (count),
    .empty_res  (empty_res)
  );

endmodule
